@@ rtl/rrt_pkg.sv @@
// rrt_pkg: shared types, codes and helpers of the route table engine
// no dependencies; used by rrt_eval, the engine top and the testbench
package rrt_pkg;

	// default geometry
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int NUM_PORTS_DEF   = 4;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam int PORT_W   = 2;
	localparam int METRIC_W = 5;
	localparam int ADV_W    = 16;
	localparam int MODE_W   = 2;
	localparam int ACT_W    = 3;

	localparam logic [METRIC_W-1:0] INF_METRIC    = 5'd16;
	localparam logic [METRIC_W-1:0] DIRECT_METRIC = 5'd1;
	localparam logic [ADV_W-1:0]    ADV_SAT       = 16'd15;

	typedef enum logic [MODE_W-1:0] {
		MODE_RECV   = 2'd0,
		MODE_DIRECT = 2'd1,
		MODE_DUMP   = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_IGNORED  = 3'd0,
		ACT_UPDATED  = 3'd1,
		ACT_ERASED   = 3'd2,
		ACT_INSERTED = 3'd3,
		ACT_FULL     = 3'd4,
		ACT_DUMP     = 3'd5,
		ACT_EMPTY    = 3'd6
	} act_t;

	// one table slot as stored in the ram
	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    len;
		logic [ADDR_W-1:0]   nexthop;
		logic [PORT_W-1:0]   port;
		logic [METRIC_W-1:0] metric;
	} slot_t;

	// per-slot verdict of the compare unit
	typedef struct packed {
		logic                match;
		logic                upd;
		logic [ADDR_W-1:0]   mask;
		logic [METRIC_W-1:0] dump_metric;
	} eval_t;

	// prefix length: nibble counts summed over eight steps
	function automatic logic [LEN_W-1:0] popcount(input logic [ADDR_W-1:0] v);
		logic [LEN_W-1:0] acc;
		logic [2:0]       nib;
		acc = '0;
		for (int n = 0; n < ADDR_W / 4; n++) begin
			nib = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
			acc = acc + LEN_W'(nib);
		end
		return acc;
	endfunction

	// leading ones mask of the given length
	function automatic logic [ADDR_W-1:0] len_to_mask(input logic [LEN_W-1:0] len);
		return ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

@@ rtl/rrt_ram.sv @@
// rrt_ram: generic single write port, single read port ram with registered read
// no dependencies
module rrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/rrt_eval.sv @@
// rrt_eval: shared compare unit applied to one table slot per cycle unless the walk is stalled
// depends on rrt_pkg
module rrt_eval (
	input  rrt_pkg::slot_t                   slot,
	input  logic [rrt_pkg::ADDR_W-1:0]       key_addr,
	input  logic [rrt_pkg::LEN_W-1:0]        key_len,
	input  logic [rrt_pkg::METRIC_W-1:0]     new_metric,
	input  logic [rrt_pkg::ADDR_W-1:0]       sender,
	input  logic [rrt_pkg::PORT_W-1:0]       port,
	output rrt_pkg::eval_t                   ev
);

	always_comb begin
		// exact key match on address and prefix length
		ev.match = (slot.addr == key_addr) && (slot.len == key_len);
		// route change rule: same neighbor with new metric, or a better metric
		ev.upd = ((sender == slot.nexthop) && (new_metric != slot.metric)) ||
			(new_metric < slot.metric);
		// dump view with poisoned reverse
		ev.mask = rrt_pkg::len_to_mask(slot.len);
		ev.dump_metric = (slot.port == port) ? rrt_pkg::INF_METRIC : slot.metric;
	end

endmodule

@@ rtl/rip_route_table_engine_top.sv @@
// Each item walks every table slot: a slot read is issued, then the slot is examined;
// the final result follows for modes 0 and 1 and also ends a dump. A dump entry is held
// back until the next valid slot is known; a trivially ignored item skips the walk.
// A new item is taken only in S_IDLE, once the final result is out; an output
// stall holds the walk of a dump and the final result. One ram read per cycle unless stalled.
// Reset: all slots marked invalid at once; slot contents are not cleared.
// depends on rrt_pkg, rrt_ram, rrt_eval
module rip_route_table_engine_top #(
	parameter int TABLE_DEPTH = rrt_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_PORTS   = rrt_pkg::NUM_PORTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rrt_pkg::MODE_W-1:0]       mode,
	input  logic [rrt_pkg::ADDR_W-1:0]       route_addr,
	input  logic [rrt_pkg::ADDR_W-1:0]       route_mask,
	input  logic [rrt_pkg::ADDR_W-1:0]       route_nexthop,
	input  logic [rrt_pkg::ADV_W-1:0]        route_metric,
	input  logic [rrt_pkg::ADDR_W-1:0]       sender_addr,
	input  logic [rrt_pkg::PORT_W-1:0]       port_number,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rrt_pkg::ACT_W-1:0]        action,
	output logic [rrt_pkg::ADDR_W-1:0]       out_addr,
	output logic [rrt_pkg::ADDR_W-1:0]       out_mask,
	output logic [rrt_pkg::METRIC_W-1:0]     out_metric,
	output logic                             last
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t state_q;

	// latched item
	rrt_pkg::mode_t                 mode_q;
	logic [rrt_pkg::ADDR_W-1:0]     addr_q;
	logic [rrt_pkg::LEN_W-1:0]      len_q;
	logic [rrt_pkg::ADDR_W-1:0]     nh_q;
	logic [rrt_pkg::ADDR_W-1:0]     sender_q;
	logic [rrt_pkg::PORT_W-1:0]     port_q;
	logic [rrt_pkg::METRIC_W-1:0]   metric_q;
	logic                           skip_q;

	// slot walk
	logic [IW-1:0] idx_q;
	logic          issue_done_q;
	logic          chk_s1;
	logic [IW-1:0] idx_s1;

	// search results
	logic          found_q;
	logic [IW-1:0] hit_idx_q;
	logic          hit_upd_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	// dump entry held back until the next one is known
	logic                           pend_q;
	logic [rrt_pkg::ADDR_W-1:0]     pend_addr_q;
	logic [rrt_pkg::ADDR_W-1:0]     pend_mask_q;
	logic [rrt_pkg::METRIC_W-1:0]   pend_metric_q;

	// output register
	logic                           out_valid_q;
	rrt_pkg::act_t                  action_q;
	logic [rrt_pkg::ADDR_W-1:0]     out_addr_q;
	logic [rrt_pkg::ADDR_W-1:0]     out_mask_q;
	logic [rrt_pkg::METRIC_W-1:0]   out_metric_q;
	logic                           last_q;

	logic [TABLE_DEPTH-1:0] valid_q;

	logic                   can_load;
	logic                   s1_live;
	logic                   stall;
	logic                   issue;
	logic                   out_load;
	logic [$bits(rrt_pkg::slot_t)-1:0] rd_data;
	rrt_pkg::slot_t         rd_slot;
	rrt_pkg::slot_t         wr_slot;
	rrt_pkg::eval_t         ev;

	logic                   fin_write;
	logic [IW-1:0]          fin_idx;
	logic                   fin_set;
	logic                   fin_clr;
	rrt_pkg::act_t          fin_act;
	logic                   wr_en;

	logic                   in_skip;

	// handshake and walk control
	assign in_ready  = (state_q == S_IDLE);
	assign can_load  = !out_valid_q || out_ready;
	assign s1_live   = chk_s1 && valid_q[idx_s1];
	assign stall     = (state_q == S_SCAN) && (mode_q == rrt_pkg::MODE_DUMP) &&
		s1_live && pend_q && !can_load;
	assign issue     = (state_q == S_SCAN) && !issue_done_q && !stall;
	assign rd_slot   = rrt_pkg::slot_t'(rd_data);
	assign wr_slot   = '{addr: addr_q, len: len_q, nexthop: nh_q, port: port_q,
		metric: metric_q};
	assign wr_en     = (state_q == S_FIN) && can_load && fin_write;

	// output register loaded this cycle
	assign out_load  = ((state_q == S_FIN) && can_load) ||
		((state_q == S_SCAN) && (mode_q == rrt_pkg::MODE_DUMP) && !stall &&
		s1_live && pend_q);

	// trivially ignored item
	assign in_skip = (rrt_pkg::mode_t'(mode) == rrt_pkg::MODE_RSVD) ||
		((rrt_pkg::mode_t'(mode) != rrt_pkg::MODE_DUMP) &&
		(32'(port_number) >= NUM_PORTS));

	rrt_ram #(
		.WIDTH ($bits(rrt_pkg::slot_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fin_idx),
		.wr_data (wr_slot),
		.rd_en   (issue),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	rrt_eval u_eval (
		.slot       (rd_slot),
		.key_addr   (addr_q),
		.key_len    (len_q),
		.new_metric (metric_q),
		.sender     (sender_q),
		.port       (port_q),
		.ev         (ev)
	);

	// final decision once the walk is over
	always_comb begin
		fin_write = 1'b0;
		fin_idx   = hit_idx_q;
		fin_set   = 1'b0;
		fin_clr   = 1'b0;
		fin_act   = rrt_pkg::ACT_IGNORED;
		priority if (skip_q) begin
			fin_act = rrt_pkg::ACT_IGNORED;
		end else if (mode_q == rrt_pkg::MODE_DUMP) begin
			fin_act = pend_q ? rrt_pkg::ACT_DUMP : rrt_pkg::ACT_EMPTY;
		end else if (found_q) begin
			if (mode_q == rrt_pkg::MODE_DIRECT) begin
				fin_write = 1'b1;
				fin_act   = rrt_pkg::ACT_UPDATED;
			end else if (hit_upd_q) begin
				if (metric_q == rrt_pkg::INF_METRIC) begin
					fin_clr = 1'b1;
					fin_act = rrt_pkg::ACT_ERASED;
				end else begin
					fin_write = 1'b1;
					fin_act   = rrt_pkg::ACT_UPDATED;
				end
			end
		end else if ((mode_q == rrt_pkg::MODE_RECV) &&
			(metric_q == rrt_pkg::INF_METRIC)) begin
			fin_act = rrt_pkg::ACT_IGNORED;
		end else if (free_found_q) begin
			fin_write = 1'b1;
			fin_idx   = free_idx_q;
			fin_set   = 1'b1;
			fin_act   = rrt_pkg::ACT_INSERTED;
		end else begin
			fin_act = rrt_pkg::ACT_FULL;
		end
	end

	// sequencer, table valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= rrt_pkg::MODE_RECV;
			addr_q        <= '0;
			len_q         <= '0;
			nh_q          <= '0;
			sender_q      <= '0;
			port_q        <= '0;
			metric_q      <= '0;
			skip_q        <= 1'b0;
			idx_q         <= '0;
			issue_done_q  <= 1'b0;
			chk_s1        <= 1'b0;
			idx_s1        <= '0;
			found_q       <= 1'b0;
			hit_idx_q     <= '0;
			hit_upd_q     <= 1'b0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			pend_q        <= 1'b0;
			pend_addr_q   <= '0;
			pend_mask_q   <= '0;
			pend_metric_q <= '0;
			out_valid_q   <= 1'b0;
			action_q      <= rrt_pkg::ACT_IGNORED;
			out_addr_q    <= '0;
			out_mask_q    <= '0;
			out_metric_q  <= '0;
			last_q        <= 1'b0;
			valid_q       <= '0;
		end else begin
			// result taken downstream with nothing new behind it
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q       <= rrt_pkg::mode_t'(mode);
						addr_q       <= route_addr;
						len_q        <= rrt_pkg::popcount(route_mask);
						sender_q     <= sender_addr;
						port_q       <= port_number;
						skip_q       <= in_skip;
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						chk_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						pend_q       <= 1'b0;
						// resolve metric and next hop per mode
						if (rrt_pkg::mode_t'(mode) == rrt_pkg::MODE_DIRECT) begin
							metric_q <= rrt_pkg::DIRECT_METRIC;
							nh_q     <= '0;
						end else begin
							metric_q <= (route_metric >= rrt_pkg::ADV_SAT) ?
								rrt_pkg::INF_METRIC :
								rrt_pkg::METRIC_W'(route_metric) + 1'b1;
							nh_q     <= (route_nexthop == '0) ? sender_addr : route_nexthop;
						end
						state_q <= in_skip ? S_FIN : S_SCAN;
					end
				end

				S_SCAN: begin
					if (!stall) begin
						// issue next slot read
						chk_s1 <= issue;
						if (issue) begin
							idx_s1 <= idx_q;
							if (idx_q == LAST_IDX) begin
								issue_done_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						// examine the slot returned by the registered read
						if (chk_s1) begin
							if (mode_q == rrt_pkg::MODE_DUMP) begin
								if (s1_live) begin
									if (pend_q) begin
										out_valid_q  <= 1'b1;
										action_q     <= rrt_pkg::ACT_DUMP;
										out_addr_q   <= pend_addr_q;
										out_mask_q   <= pend_mask_q;
										out_metric_q <= pend_metric_q;
										last_q       <= 1'b0;
									end
									pend_q        <= 1'b1;
									pend_addr_q   <= rd_slot.addr;
									pend_mask_q   <= ev.mask;
									pend_metric_q <= ev.dump_metric;
								end
							end else begin
								if (s1_live && ev.match && !found_q) begin
									found_q   <= 1'b1;
									hit_idx_q <= idx_s1;
									hit_upd_q <= ev.upd;
								end
								if (!valid_q[idx_s1] && !free_found_q) begin
									free_found_q <= 1'b1;
									free_idx_q   <= idx_s1;
								end
							end
							if (idx_s1 == LAST_IDX) begin
								state_q <= S_FIN;
							end
						end
					end
				end

				S_FIN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						action_q    <= fin_act;
						last_q      <= 1'b1;
						if (fin_act == rrt_pkg::ACT_DUMP) begin
							out_addr_q   <= pend_addr_q;
							out_mask_q   <= pend_mask_q;
							out_metric_q <= pend_metric_q;
						end else begin
							out_addr_q   <= '0;
							out_mask_q   <= '0;
							out_metric_q <= '0;
						end
						if (fin_set) begin
							valid_q[fin_idx] <= 1'b1;
						end
						if (fin_clr) begin
							valid_q[fin_idx] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign out_addr   = out_addr_q;
	assign out_mask   = out_mask_q;
	assign out_metric = out_metric_q;
	assign last       = last_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench for rip_route_table_engine_top: directed and random route items
// checked against a scoreboard that keeps its own copy of the route table
// depends on rrt_pkg and the engine rtl
module testbench;

	localparam int DEPTH    = rrt_pkg::TABLE_DEPTH_DEF;
	localparam int NPORTS   = rrt_pkg::NUM_PORTS_DEF;
	localparam int N_RANDOM = 420;
	localparam int N_KEYS   = 48;
	localparam int N_PEERS  = 3;

	// one input item and one result item
	typedef struct {
		rrt_pkg::mode_t mode;
		logic [31:0]    addr;
		logic [31:0]    mask;
		logic [31:0]    nexthop;
		logic [15:0]    adv;
		logic [31:0]    sender;
		logic [1:0]     port;
	} route_item_t;

	typedef struct {
		rrt_pkg::act_t  act;
		logic [31:0]    addr;
		logic [31:0]    mask;
		logic [4:0]     metric;
		logic           fin;
	} route_result_t;

	// route table copy, expected results and mismatch tally
	class route_table_model;
		route_result_t due_results[$];
		bit            live [DEPTH];
		logic [31:0]   key_addr [DEPTH];
		int unsigned   key_len [DEPTH];
		logic [31:0]   hop [DEPTH];
		logic [1:0]    iface [DEPTH];
		logic [4:0]    cost [DEPTH];
		int            mismatches;

		function new();
			mismatches = 0;
			for (int i = 0; i < DEPTH; i++)
				live[i] = 1'b0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function logic [31:0] prefix_mask(int unsigned len);
			if (len == 0)
				return 32'h0;
			return 32'hFFFF_FFFF << (32 - len);
		endfunction

		function void queue_result(rrt_pkg::act_t act, logic [31:0] addr,
				logic [31:0] mask, logic [4:0] metric, logic fin);
			route_result_t r;
			r.act    = act;
			r.addr   = addr;
			r.mask   = mask;
			r.metric = metric;
			r.fin    = fin;
			due_results.push_back(r);
		endfunction

		// work out the results of one accepted item and update the table
		function void apply_item(route_item_t it);
			int unsigned   len;
			int            hit;
			int            spare;
			int            top;
			logic [16:0]   sum;
			logic [4:0]    metric;
			logic [31:0]   nh;
			rrt_pkg::act_t act;
			len = $countones(it.mask);
			act = rrt_pkg::ACT_IGNORED;

			// dump with poisoned reverse toward the output port
			if (it.mode == rrt_pkg::MODE_DUMP) begin
				top = -1;
				for (int i = 0; i < DEPTH; i++)
					if (live[i])
						top = i;
				if (top < 0) begin
					queue_result(rrt_pkg::ACT_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1);
				end else begin
					for (int i = 0; i < DEPTH; i++)
						if (live[i])
							queue_result(rrt_pkg::ACT_DUMP, key_addr[i],
								prefix_mask(key_len[i]),
								(iface[i] == it.port) ? rrt_pkg::INF_METRIC : cost[i],
								i == top);
				end
				return;
			end

			if (it.mode == rrt_pkg::MODE_RSVD || int'(it.port) >= NPORTS) begin
				queue_result(rrt_pkg::ACT_IGNORED, 32'h0, 32'h0, 5'd0, 1'b1);
				return;
			end

			// exact key lookup and lowest free slot
			hit = -1;
			spare = -1;
			for (int i = DEPTH - 1; i >= 0; i--) begin
				if (live[i] && key_addr[i] == it.addr && key_len[i] == len)
					hit = i;
				if (!live[i])
					spare = i;
			end

			if (it.mode == rrt_pkg::MODE_DIRECT) begin
				if (hit >= 0) begin
					act = rrt_pkg::ACT_UPDATED;
				end else if (spare < 0) begin
					act = rrt_pkg::ACT_FULL;
				end else begin
					hit = spare;
					act = rrt_pkg::ACT_INSERTED;
				end
				if (act != rrt_pkg::ACT_FULL) begin
					live[hit]     = 1'b1;
					key_addr[hit] = it.addr;
					key_len[hit]  = len;
					hop[hit]      = 32'h0;
					iface[hit]    = it.port;
					cost[hit]     = rrt_pkg::DIRECT_METRIC;
				end
			end else begin
				// received route: saturate metric, zero next hop means the sender
				sum = 17'(it.adv) + 17'd1;
				metric = (sum >= 17'(rrt_pkg::INF_METRIC)) ? rrt_pkg::INF_METRIC : sum[4:0];
				nh = (it.nexthop == 32'h0) ? it.sender : it.nexthop;
				if (hit >= 0) begin
					if ((it.sender == hop[hit] && metric != cost[hit]) ||
						metric < cost[hit]) begin
						if (metric == rrt_pkg::INF_METRIC) begin
							live[hit] = 1'b0;
							act = rrt_pkg::ACT_ERASED;
						end else begin
							hop[hit]   = nh;
							iface[hit] = it.port;
							cost[hit]  = metric;
							act = rrt_pkg::ACT_UPDATED;
						end
					end
				end else if (metric != rrt_pkg::INF_METRIC) begin
					if (spare < 0) begin
						act = rrt_pkg::ACT_FULL;
					end else begin
						live[spare]     = 1'b1;
						key_addr[spare] = it.addr;
						key_len[spare]  = len;
						hop[spare]      = nh;
						iface[spare]    = it.port;
						cost[spare]     = metric;
						act = rrt_pkg::ACT_INSERTED;
					end
				end
			end
			queue_result(act, 32'h0, 32'h0, 5'd0, 1'b1);
		endfunction

		// compare one result with the oldest expectation
		function void check_result(route_result_t got);
			route_result_t want;
			bit            bad;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result act=%0d addr=%h mask=%h metric=%0d last=%0b",
						$time, got.act, got.addr, got.mask, got.metric, got.fin);
				return;
			end
			want = due_results.pop_front();
			bad = (got.act !== want.act) || (got.addr !== want.addr) ||
				(got.mask !== want.mask) || (got.metric !== want.metric) ||
				(got.fin !== want.fin);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch expected act=%0d addr=%h mask=%h metric=%0d last=%0b",
						$time, want.act, want.addr, want.mask, want.metric, want.fin);
					$display("%0t:          got      act=%0d addr=%h mask=%h metric=%0d last=%0b",
						$time, got.act, got.addr, got.mask, got.metric, got.fin);
				end
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [rrt_pkg::MODE_W-1:0]   mode;
	logic [rrt_pkg::ADDR_W-1:0]   route_addr;
	logic [rrt_pkg::ADDR_W-1:0]   route_mask;
	logic [rrt_pkg::ADDR_W-1:0]   route_nexthop;
	logic [rrt_pkg::ADV_W-1:0]    route_metric;
	logic [rrt_pkg::ADDR_W-1:0]   sender_addr;
	logic [rrt_pkg::PORT_W-1:0]   port_number;
	logic                         out_valid;
	logic                         out_ready;
	logic [rrt_pkg::ACT_W-1:0]    action;
	logic [rrt_pkg::ADDR_W-1:0]   out_addr;
	logic [rrt_pkg::ADDR_W-1:0]   out_mask;
	logic [rrt_pkg::METRIC_W-1:0] out_metric;
	logic                         last;

	route_table_model table_model = new();
	bit                calm = 1'b0;
	logic [31:0]       key_addr_pool [N_KEYS];
	logic [31:0]       key_mask_pool [N_KEYS];
	logic [31:0]       peers [N_PEERS];

	rip_route_table_engine_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.route_addr    (route_addr),
		.route_mask    (route_mask),
		.route_nexthop (route_nexthop),
		.route_metric  (route_metric),
		.sender_addr   (sender_addr),
		.port_number   (port_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.out_addr      (out_addr),
		.out_mask      (out_mask),
		.out_metric    (out_metric),
		.last          (last)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver stalls at random outside the calm stretch
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 12);
	end

	// result monitor
	always @(posedge clk) begin
		route_result_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got.act    = rrt_pkg::act_t'(action);
			got.addr   = out_addr;
			got.mask   = out_mask;
			got.metric = out_metric;
			got.fin    = last;
			table_model.check_result(got);
		end
	end

	function automatic route_item_t route_item(rrt_pkg::mode_t m, logic [31:0] addr,
			logic [31:0] mask, logic [31:0] nh, logic [15:0] adv,
			logic [31:0] sender, logic [1:0] port);
		route_item_t it;
		it.mode    = m;
		it.addr    = addr;
		it.mask    = mask;
		it.nexthop = nh;
		it.adv     = adv;
		it.sender  = sender;
		it.port    = port;
		return it;
	endfunction

	// present one item from a falling edge until it is accepted
	task automatic send_item(route_item_t it);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= it.mode;
		route_addr    <= it.addr;
		route_mask    <= it.mask;
		route_nexthop <= it.nexthop;
		route_metric  <= it.adv;
		sender_addr   <= it.sender;
		port_number   <= it.port;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		table_model.apply_item(it);
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (table_model.pending() != 0)
			@(negedge clk);
	endtask

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		route_item_t it;
		int          r;
		int          k;
		int unsigned len;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_ready     = 1'b0;
		mode          = rrt_pkg::MODE_RECV;
		route_addr    = '0;
		route_mask    = '0;
		route_nexthop = '0;
		route_metric  = '0;
		sender_addr   = '0;
		port_number   = '0;

		// key and neighbor pools for the random part
		for (int i = 0; i < N_KEYS; i++) begin
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(32);
				key_mask_pool[i] = table_model.prefix_mask(len);
			end else begin
				key_mask_pool[i] = $urandom;
			end
			key_addr_pool[i] = $urandom;
		end
		for (int i = 0; i < N_PEERS; i++)
			peers[i] = $urandom;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty dump, reserved mode, infinite unknown routes
		send_item(route_item(rrt_pkg::MODE_DUMP, 32'h0, 32'h0, 32'h0, 16'd0, 32'h0, 2'd0));
		send_item(route_item(rrt_pkg::MODE_RSVD, '1, '1, '1, '1, '1, 2'd3));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd15, 32'hC0A8_0001, 2'd1));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'hFFFF, 32'hC0A8_0001, 2'd1));
		// insert via the sender, worse metric from the next hop, then lower metric
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd0, 32'hC0A8_0001, 2'd1));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd3, 32'hC0A8_0001, 2'd1));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd5, 32'hC0A8_0002, 2'd2));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000,
			32'h0B00_0001, 16'd1, 32'hC0A8_0002, 2'd2));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd1, 32'hC0A8_0002, 2'd2));
		// direct route insert and replace
		send_item(route_item(rrt_pkg::MODE_DIRECT, 32'hAC10_0000, 32'hFFF0_0000,
			32'h1234_5678, 16'd9, 32'h0, 2'd2));
		send_item(route_item(rrt_pkg::MODE_DIRECT, 32'hAC10_0000, 32'hFFF0_0000, 32'h0,
			16'd0, 32'h0, 2'd3));
		// mask extremes and a non-contiguous mask
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0, 32'h0, 32'h0, 16'd0,
			32'hC0A8_0003, 2'd0));
		send_item(route_item(rrt_pkg::MODE_RECV, '1, '1, '1, 16'd14, '1, 2'd3));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h1234_5678, 32'h0F0F_00F0, 32'h0,
			16'd2, 32'hC0A8_0001, 2'd1));
		send_item(route_item(rrt_pkg::MODE_DUMP, 32'h0, 32'h0, 32'h0, 16'd0, 32'h0, 2'd1));
		send_item(route_item(rrt_pkg::MODE_DUMP, '1, '1, '1, '1, '1, 2'd3));
		// erase from the next hop, then the freed slot is reused
		send_item(route_item(rrt_pkg::MODE_RECV, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd16, 32'h0B00_0001, 2'd0));
		send_item(route_item(rrt_pkg::MODE_DIRECT, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
			16'd0, 32'h0, 2'd0));
		send_item(route_item(rrt_pkg::MODE_RECV, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0,
			16'd0, 32'hC0A8_0001, 2'd0));
		send_item(route_item(rrt_pkg::MODE_DUMP, 32'h0, 32'h0, 32'h0, 16'd0, 32'h0, 2'd0));

		// hold the sender until the engine has emptied out
		in_valid <= 1'b0;
		drain_results();
		@(negedge clk);

		// random part: mostly routes on a small key pool so the table fills and churns
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 200 && n < 280);
			r = $urandom_range(99);
			k = $urandom_range(N_KEYS - 1);
			it = route_item(rrt_pkg::mode_t'($urandom_range(3)), $urandom, $urandom,
				$urandom, 16'($urandom_range(65535)), $urandom, 2'($urandom_range(3)));
			if (r >= 8 && r < 18) begin
				it.mode = rrt_pkg::MODE_DUMP;
			end else if (r >= 18 && r < 30) begin
				it.mode = rrt_pkg::MODE_DIRECT;
				it.addr = key_addr_pool[k];
				it.mask = key_mask_pool[k];
			end else if (r >= 30) begin
				it.mode   = rrt_pkg::MODE_RECV;
				it.addr   = key_addr_pool[k];
				it.mask   = key_mask_pool[k];
				it.sender = peers[$urandom_range(N_PEERS - 1)];
				r = $urandom_range(99);
				if (r < 60)
					it.nexthop = 32'h0;
				else if (r < 80)
					it.nexthop = peers[$urandom_range(N_PEERS - 1)];
				if ($urandom_range(99) < 30)
					it.adv = $urandom_range(1) ? 16'($urandom_range(65535, 15))
						: 16'($urandom_range(17, 15));
				else
					it.adv = 16'($urandom_range(14));
			end
			send_item(it);
		end
		calm = 1'b0;

		// wait for the tail, then allow the pipeline to settle
		in_valid <= 1'b0;
		drain_results();
		repeat (DEPTH + 8) @(negedge clk);
		if (table_model.mismatches == 0 && table_model.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
